/* hdl/fcd_pkg.sv */
// Shared constants and types for the fan curve duty controller.
package fcd_pkg;

    // Curve and fault limits.
    localparam int MAX_POINTS  = 8;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int FAULT_TICKS = 8;

    // Sample validity, smoothing and duty constants.
    localparam logic [12:0] VALID_HIGH = 13'd2400;
    localparam logic [8:0]  EMA_GAIN   = 9'd102;
    localparam logic [6:0]  PUMP_MIN   = 7'd20;
    localparam logic [6:0]  EMPTY_DUTY = 7'd50;
    localparam logic [6:0]  DUTY_MAX   = 7'd100;

    // Divider operand widths: numerator 2*num+den, divisor 2*den, quotient of a byte.
    localparam int NUM_W = 30;
    localparam int DEN_W = 21;
    localparam int QUO_W = 8;

    // Register indexes of the configuration port.
    typedef enum logic [3:0] {
        REG_CURVE_TEMPS  = 4'd0,
        REG_CURVE_DUTIES = 4'd1,
        REG_POINT_COUNT  = 4'd2,
        REG_RISE_RATE    = 4'd3,
        REG_FALL_RATE    = 4'd4,
        REG_DUTY_FLOOR   = 4'd5,
        REG_PUMP_MODE    = 4'd6,
        REG_FAULT_EXEMPT = 4'd7
    } t_reg_idx;

    // Control between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

/* hdl/fan_curve_duty_controller.sv */
// Top level of the fan curve duty controller: sequencer, shared multiplier, registers.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_temp_sample, i_force_rewrite
//  out     | output    | o_out_valid / i_out_stall| o_write_valid, o_duty, o_sensor_fault,
//          |           |                         | o_release_channel
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A bad sample goes from the check state straight to emit and the output register, and
// the sequencer takes no new sample until it is back in idle. A good sample passes check,
// the smoothing multiply and add, lookup, the search (one step per curve point searched,
// up to 7), the interpolation (both multiplier products, divider load and the 8-step
// serial divider), post processing and emit. The first good sample after a restart skips
// the smoothing multiply and add, and a sample at or beyond the curve ends or on an empty
// curve skips search and interpolation.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled result holds the sequencer until the output register frees.
module fan_curve_duty_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [12:0] i_temp_sample,
    input  logic               i_force_rewrite,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_write_valid,
    output logic [6:0]         o_duty,
    output logic               o_sensor_fault,
    output logic               o_release_channel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_EMA_MUL, S_EMA_ADD, S_LOOK, S_SRCH,
        S_MUL1, S_MUL2, S_DIVLD, S_DIV, S_POST, S_EMIT
    } t_state;

    localparam int IW = fcd_pkg::IDX_W;

    t_state r_state;

    // Configuration registers.
    logic [63:0] r_curve_temps, r_curve_duties;
    logic [3:0]  r_point_count;
    logic [6:0]  r_rise_rate, r_fall_rate, r_duty_floor;
    logic        r_pump_mode, r_fault_exempt;

    // Controller state.
    logic        r_smooth_valid, r_last_valid, r_channel_driven;
    logic [19:0] r_smooth;
    logic [6:0]  r_last_duty;
    logic [3:0]  r_bad_streak;

    // Working registers.
    logic signed [12:0] r_raw;
    logic               r_force;
    logic [IW-1:0]      r_k;
    logic [7:0]         r_prev_t, r_prev_y, r_ya, r_yb, r_target;
    logic [19:0]        r_den, r_e;
    logic signed [30:0] r_prod;
    logic [28:0]        r_acc;
    logic               r_res_wv, r_res_fault, r_res_rel;
    logic [6:0]         r_res_duty;

    // Output register.
    logic       r_out_valid, r_write_valid, r_sensor_fault, r_release;
    logic [6:0] r_duty;
    logic       w_emit;

    // Divider link.
    fcd_pkg::t_div_ctl w_div_ctl;
    fcd_pkg::t_div_sts w_div_sts;
    logic [fcd_pkg::NUM_W-1:0] w_div_num;
    logic [fcd_pkg::QUO_W-1:0] w_quot;

    // Curve point read port, one index per cycle.
    logic [3:0]    w_n;
    logic [IW-1:0] w_ridx;
    logic [7:0]    w_pt_t, w_pt_y;
    logic [19:0]   w_pt_x, w_x0, w_xprev;

    assign w_n    = (r_point_count > 4'(fcd_pkg::MAX_POINTS)) ?
                    4'(fcd_pkg::MAX_POINTS) : r_point_count;
    assign w_ridx = (r_state == S_LOOK) ? IW'(w_n - 4'd1) : r_k;
    assign w_pt_t = r_curve_temps[8*w_ridx +: 8];
    assign w_pt_y = r_curve_duties[8*w_ridx +: 8];
    assign w_pt_x = {w_pt_t, 12'd0};
    assign w_x0   = {r_curve_temps[7:0], 12'd0};
    assign w_xprev = {r_prev_t, 12'd0};

    // Sample check.
    logic w_good;
    assign w_good = (r_raw > 13'sd0) && (r_raw < $signed(fcd_pkg::VALID_HIGH));

    // Shared multiplier, operands chosen by the sequencer.
    logic signed [20:0] w_diff;
    logic signed [21:0] w_ma;
    logic signed [8:0]  w_mb;
    logic signed [30:0] w_prod;
    logic signed [30:0] w_q;

    assign w_diff = $signed({1'b0, r_raw[11:0], 8'd0}) - $signed({1'b0, r_smooth});

    always_comb begin
        unique case (r_state)
            S_EMA_MUL: begin
                w_ma = 22'(w_diff);
                w_mb = $signed(fcd_pkg::EMA_GAIN);
            end
            S_MUL1: begin
                w_ma = $signed({2'b00, r_den - r_e});
                w_mb = $signed({1'b0, r_ya});
            end
            default: begin
                w_ma = $signed({2'b00, r_e});
                w_mb = $signed({1'b0, r_yb});
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_q    = (r_prod + 31'sd128) >>> 8;

    // Divider operands: round half up of num/den as (2*num + den) / (2*den).
    assign w_div_num = {r_acc + 29'(r_prod[27:0]), 1'b0} + fcd_pkg::NUM_W'(r_den);
    assign w_div_ctl.start = (r_state == S_DIVLD);

    fcd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_div_ctl),
        .i_num  (w_div_num),
        .i_den  ({r_den, 1'b0}),
        .o_sts  (w_div_sts),
        .o_quot (w_quot)
    );

    // Post processing: clamp, floor, slew limits and deadband.
    logic [6:0] w_clamp, w_floor, w_slew, w_up, w_dn;
    logic [7:0] w_last_up;
    logic       w_skip;

    always_comb begin
        w_clamp = (r_target > 8'(fcd_pkg::DUTY_MAX)) ? fcd_pkg::DUTY_MAX : r_target[6:0];
        if (r_pump_mode) begin
            w_floor = (w_clamp < fcd_pkg::PUMP_MIN) ? fcd_pkg::PUMP_MIN : w_clamp;
        end else if (w_clamp != 7'd0 && w_clamp < r_duty_floor) begin
            w_floor = 7'd0;
        end else begin
            w_floor = w_clamp;
        end
        w_up      = (r_rise_rate == 7'd0) ? 7'd1 : r_rise_rate;
        w_dn      = (r_fall_rate == 7'd0) ? 7'd1 : r_fall_rate;
        w_last_up = {1'b0, r_last_duty} + {1'b0, w_up};
        w_slew    = w_floor;
        w_skip    = 1'b0;
        if (r_last_valid) begin
            if ({1'b0, w_floor} > w_last_up) begin
                w_slew = w_last_up[6:0];
            end else if (({1'b0, w_floor} + {1'b0, w_dn}) < {1'b0, r_last_duty}) begin
                w_slew = r_last_duty - w_dn;
            end
            if (!r_force) begin
                if (w_slew == r_last_duty) begin
                    w_skip = 1'b1;
                end else if ((w_slew == r_last_duty + 7'd1 || w_slew + 7'd1 == r_last_duty)
                             && w_slew != 7'd0 && w_slew != fcd_pkg::DUTY_MAX) begin
                    w_skip = 1'b1;
                end
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // The finished result moves into the output register once it is free.
    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // Sequencer, state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_curve_temps    <= '0;
            r_curve_duties   <= '0;
            r_point_count    <= '0;
            r_rise_rate      <= fcd_pkg::DUTY_MAX;
            r_fall_rate      <= fcd_pkg::DUTY_MAX;
            r_duty_floor     <= '0;
            r_pump_mode      <= 1'b0;
            r_fault_exempt   <= 1'b0;
            r_smooth_valid   <= 1'b0;
            r_smooth         <= '0;
            r_last_valid     <= 1'b0;
            r_last_duty      <= '0;
            r_bad_streak     <= '0;
            r_channel_driven <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_prod <= w_prod;

            // Output register drains when taken and nothing new replaces it.
            if (r_out_valid && !i_out_stall && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_raw   <= i_temp_sample;
                        r_force <= i_force_rewrite;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_wv    <= 1'b0;
                    r_res_duty  <= '0;
                    r_res_fault <= 1'b0;
                    r_res_rel   <= 1'b0;
                    if (!w_good) begin
                        r_smooth_valid <= 1'b0;
                        if (!r_fault_exempt) begin
                            if (r_bad_streak < 4'(fcd_pkg::FAULT_TICKS)) begin
                                r_bad_streak <= r_bad_streak + 4'd1;
                            end
                            if (r_bad_streak >= 4'(fcd_pkg::FAULT_TICKS - 1)) begin
                                r_res_fault <= 1'b1;
                                if (r_channel_driven) begin
                                    r_channel_driven <= 1'b0;
                                    r_last_valid     <= 1'b0;
                                    r_res_rel        <= 1'b1;
                                end
                            end
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_bad_streak <= '0;
                        if (!r_smooth_valid) begin
                            r_smooth       <= {r_raw[11:0], 8'd0};
                            r_smooth_valid <= 1'b1;
                            r_state        <= S_LOOK;
                        end else begin
                            r_state <= S_EMA_MUL;
                        end
                    end
                end
                S_EMA_MUL: begin
                    r_state <= S_EMA_ADD;
                end
                S_EMA_ADD: begin
                    r_smooth <= r_smooth + w_q[19:0];
                    r_state  <= S_LOOK;
                end
                S_LOOK: begin
                    r_k      <= IW'(1);
                    r_prev_t <= r_curve_temps[7:0];
                    r_prev_y <= r_curve_duties[7:0];
                    if (w_n == 4'd0) begin
                        r_target <= {1'b0, fcd_pkg::EMPTY_DUTY};
                        r_state  <= S_POST;
                    end else if (r_smooth <= w_x0) begin
                        r_target <= r_curve_duties[7:0];
                        r_state  <= S_POST;
                    end else if (r_smooth >= w_pt_x) begin
                        r_target <= w_pt_y;
                        r_state  <= S_POST;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    // Segment found: the point below is strictly under the sample.
                    if (r_smooth <= w_pt_x) begin
                        r_ya    <= r_prev_y;
                        r_yb    <= w_pt_y;
                        r_den   <= w_pt_x - w_xprev;
                        r_e     <= r_smooth - w_xprev;
                        r_state <= S_MUL1;
                    end else begin
                        r_prev_t <= w_pt_t;
                        r_prev_y <= w_pt_y;
                        r_k      <= r_k + IW'(1);
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= 29'(r_prod[27:0]);
                    r_state <= S_DIVLD;
                end
                S_DIVLD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_target <= w_quot;
                        r_state  <= S_POST;
                    end
                end
                S_POST: begin
                    if (!w_skip) begin
                        r_res_wv         <= 1'b1;
                        r_res_duty       <= w_slew;
                        r_last_duty      <= w_slew;
                        r_last_valid     <= 1'b1;
                        r_channel_driven <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_valid    <= 1'b1;
                        r_write_valid  <= r_res_wv;
                        r_duty         <= r_res_duty;
                        r_sensor_fault <= r_res_fault;
                        r_release      <= r_res_rel;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration write: any known register restarts smoothing and slew.
            if (i_cfg_valid && o_cfg_ready && i_cfg_index <= fcd_pkg::REG_FAULT_EXEMPT) begin
                r_last_valid   <= 1'b0;
                r_smooth_valid <= 1'b0;
                unique case (fcd_pkg::t_reg_idx'(i_cfg_index))
                    fcd_pkg::REG_CURVE_TEMPS:  r_curve_temps  <= i_cfg_data;
                    fcd_pkg::REG_CURVE_DUTIES: r_curve_duties <= i_cfg_data;
                    fcd_pkg::REG_POINT_COUNT:  r_point_count  <= i_cfg_data[3:0];
                    fcd_pkg::REG_RISE_RATE:    r_rise_rate    <= i_cfg_data[6:0];
                    fcd_pkg::REG_FALL_RATE:    r_fall_rate    <= i_cfg_data[6:0];
                    fcd_pkg::REG_DUTY_FLOOR:   r_duty_floor   <= i_cfg_data[6:0];
                    fcd_pkg::REG_PUMP_MODE:    r_pump_mode    <= i_cfg_data[0];
                    default:                   r_fault_exempt <= i_cfg_data[0];
                endcase
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_write_valid     = r_write_valid;
    assign o_duty            = r_duty;
    assign o_sensor_fault    = r_sensor_fault;
    assign o_release_channel = r_release;

    // A delivered duty is a percentage, and zero when nothing is written.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_duty <= fcd_pkg::DUTY_MAX)) else $error("duty above 100");
    a_duty_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_write_valid) |-> (r_duty == 7'd0)) else $error("stray duty");
    // A release only comes with a fault and never with a write.
    a_release_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_release) |-> (r_sensor_fault && !r_write_valid))
        else $error("release without fault");
    // The fault streak never passes its limit.
    a_streak_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad_streak <= 4'(fcd_pkg::FAULT_TICKS)) else $error("streak overflow");

endmodule

/* hdl/fcd_div.sv */
// Serial restoring divider, one quotient bit per cycle.
module fcd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fcd_pkg::t_div_ctl          i_ctl,
    input  logic [fcd_pkg::NUM_W-1:0]  i_num,
    input  logic [fcd_pkg::DEN_W-1:0]  i_den,
    output fcd_pkg::t_div_sts          o_sts,
    output logic [fcd_pkg::QUO_W-1:0]  o_quot
);
    localparam int SH_W  = fcd_pkg::DEN_W + fcd_pkg::QUO_W - 1;
    localparam int CNT_W = $clog2(fcd_pkg::QUO_W);

    logic [fcd_pkg::NUM_W-1:0] r_rem;
    logic [SH_W-1:0]           r_dsh;
    logic [fcd_pkg::QUO_W-1:0] r_quot;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      w_ge;

    // Trial subtraction of the shifted divisor.
    assign w_ge = (r_rem >= fcd_pkg::NUM_W'(r_dsh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(fcd_pkg::QUO_W - 1);
                r_rem  <= i_num;
                r_dsh  <= SH_W'({i_den, {(fcd_pkg::QUO_W-1){1'b0}}});
                r_quot <= '0;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - fcd_pkg::NUM_W'(r_dsh);
                end
                r_quot <= {r_quot[fcd_pkg::QUO_W-2:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

    // A start is never issued while a division runs.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy) else $error("divider restarted while busy");
    // Done follows the last busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a division");
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done longer than one cycle");

endmodule
